### hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/rtbd_pkg.sv
// Types, constants and symbol lookup for the radix text decoder.
package rtbd_pkg;

    localparam int QUEUE_DEPTH = 4;

    // alphabet_mode codes
    localparam logic [2:0] MODE_B64    = 3'd0;
    localparam logic [2:0] MODE_B64URL = 3'd1;
    localparam logic [2:0] MODE_B32    = 3'd2;
    localparam logic [2:0] MODE_B32HEX = 3'd3;
    localparam logic [2:0] MODE_B16    = 3'd4;

    // status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

    localparam logic [7:0] CHAR_PAD = 8'h3D;  // '='
    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_CR  = 8'h0D;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       end_of_string;
        logic [1:0] status;
    } t_out_item;

    typedef enum logic [1:0] {
        SK_SKIP,
        SK_PAD,
        SK_BAD,
        SK_DATA
    } t_sym_kind;

    // Classified character handed from front to back.
    typedef struct packed {
        t_sym_kind  kind;
        logic [5:0] value;
        logic [2:0] width;     // bits per symbol: 6, 5 or 4
        logic [2:0] len_mask;  // count must be zero under this mask at end
        logic       last;
    } t_sym;

    // Returns {found, value}.
    function automatic logic [6:0] symbol_lookup(input logic [2:0] mode,
                                                 input logic [7:0] c);
        logic [6:0] res;
        res = 7'd0;
        unique case (mode)
            MODE_B64, MODE_B64URL: begin
                if (c >= "A" && c <= "Z")      res = {1'b1, 6'(c - 8'd65)};
                else if (c >= "a" && c <= "z") res = {1'b1, 6'(c - 8'd97 + 8'd26)};
                else if (c >= "0" && c <= "9") res = {1'b1, 6'(c - 8'd48 + 8'd52)};
                else if (mode == MODE_B64 && c == "+")    res = {1'b1, 6'h3E};
                else if (mode == MODE_B64 && c == "/")    res = {1'b1, 6'h3F};
                else if (mode == MODE_B64URL && c == "-") res = {1'b1, 6'h3E};
                else if (mode == MODE_B64URL && c == "_") res = {1'b1, 6'h3F};
            end
            MODE_B32: begin
                if (c >= "A" && c <= "Z")      res = {1'b1, 6'(c - 8'd65)};
                else if (c >= "2" && c <= "7") res = {1'b1, 6'(c - 8'd50 + 8'd26)};
            end
            MODE_B32HEX: begin
                if (c >= "0" && c <= "9")      res = {1'b1, 6'(c - 8'd48)};
                else if (c >= "A" && c <= "V") res = {1'b1, 6'(c - 8'd65 + 8'd10)};
            end
            MODE_B16: begin
                if (c >= "0" && c <= "9")      res = {1'b1, 6'(c - 8'd48)};
                else if (c >= "A" && c <= "F") res = {1'b1, 6'(c - 8'd65 + 8'd10)};
            end
            default: res = 7'd0;
        endcase
        return res;
    endfunction

endpackage

### hdl/rtbd_fifo.sv
// Small register-based queue with push/full and pop/empty sides.
module rtbd_fifo
    import rtbd_pkg::*;
#(
    parameter int  DEPTH  = QUEUE_DEPTH,
    parameter type t_data = t_sym
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_data i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_data o_data,
    output logic  o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_data          r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### hdl/rtbd_front.sv
// Front end: classifies an incoming character under the current alphabet.
module rtbd_front
    import rtbd_pkg::*;
(
    input  logic [2:0] i_mode,
    input  t_in_item   i_item,
    output t_sym       o_sym
);
    logic [6:0] lookup;

    assign lookup = symbol_lookup(i_mode, i_item.char_code);

    always_comb begin
        o_sym.value    = lookup[5:0];
        o_sym.last     = i_item.last_char;
        o_sym.width    = 3'd4;
        o_sym.len_mask = 3'd0;
        unique case (i_mode)
            MODE_B64:    begin o_sym.width = 3'd6; o_sym.len_mask = 3'd0; end
            MODE_B64URL: begin o_sym.width = 3'd6; o_sym.len_mask = 3'd3; end
            MODE_B32:    begin o_sym.width = 3'd5; o_sym.len_mask = 3'd7; end
            MODE_B32HEX: begin o_sym.width = 3'd5; o_sym.len_mask = 3'd7; end
            MODE_B16:    begin o_sym.width = 3'd4; o_sym.len_mask = 3'd1; end
            default:     begin o_sym.width = 3'd4; o_sym.len_mask = 3'd0; end
        endcase

        if (i_mode == MODE_B64 &&
            (i_item.char_code == CHAR_CR || i_item.char_code == CHAR_LF)) begin
            o_sym.kind = SK_SKIP;
        end else if (i_mode <= MODE_B32HEX && i_item.char_code == CHAR_PAD) begin
            o_sym.kind = SK_PAD;
        end else if (!lookup[6]) begin
            o_sym.kind = SK_BAD;
        end else begin
            o_sym.kind = SK_DATA;
        end
    end

endmodule

### hdl/rtbd_back.sv
// Back end: bit accumulator, padding/error tracking and length check.
module rtbd_back
    import rtbd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_take,
    input  t_sym      i_sym,
    output t_out_item o_result
);
    logic [6:0]  r_left,     n_left;
    logic [2:0]  r_left_cnt, n_left_cnt;
    logic        r_pad,      n_pad;
    logic        r_err,      n_err;
    logic [2:0]  r_cnt,      n_cnt;

    logic [13:0] acc;
    logic [3:0]  nsum, nrem;

    always_comb begin
        n_left     = r_left;
        n_left_cnt = r_left_cnt;
        n_pad      = r_pad;
        n_err      = r_err;
        n_cnt      = r_cnt;
        acc        = (14'(r_left) << i_sym.width) | 14'(i_sym.value);
        nsum       = 4'(r_left_cnt) + 4'(i_sym.width);
        nrem       = nsum;

        o_result               = '0;
        o_result.end_of_string = i_sym.last;

        if (i_sym.kind != SK_SKIP) begin
            n_cnt = r_cnt + 3'd1;
            case (i_sym.kind)
                SK_PAD: n_pad = 1'b1;
                SK_BAD: n_err = 1'b1;
                SK_DATA: begin
                    if (r_pad) begin
                        n_err = 1'b1;
                    end else if (!r_err) begin
                        if (nsum >= 4'd8) begin
                            nrem                = nsum - 4'd8;
                            o_result.byte_valid = 1'b1;
                            o_result.data_byte  = 8'(acc >> nrem);
                            acc                 = acc & ((14'd1 << nrem) - 14'd1);
                        end
                        n_left     = acc[6:0];
                        n_left_cnt = nrem[2:0];
                    end
                end
                default: ;
            endcase
        end

        o_result.status = n_err ? STATUS_INVALID : STATUS_OK;
        if (i_sym.last) begin
            if (!n_err && (n_cnt & i_sym.len_mask) != 3'd0) begin
                o_result.status = STATUS_BAD_LEN;
            end
            n_left     = '0;
            n_left_cnt = '0;
            n_pad      = 1'b0;
            n_err      = 1'b0;
            n_cnt      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left     <= '0;
            r_left_cnt <= '0;
            r_pad      <= 1'b0;
            r_err      <= 1'b0;
            r_cnt      <= '0;
        end else if (i_take) begin
            r_left     <= n_left;
            r_left_cnt <= n_left_cnt;
            r_pad      <= n_pad;
            r_err      <= n_err;
            r_cnt      <= n_cnt;
        end
    end

endmodule

### hdl/radix_text_to_byte_decoder.sv
// Top level of the base64/base32/base16 text-to-byte decoder.
// Decodes one character per transaction and returns exactly one result per
// character: an optional byte, an end-of-string flag and a status. Sustained
// rate is one character per clock while the result queue has room. A pushed
// character is written into the classify queue, then the back end takes it
// through the bit accumulator into the result queue, from which it can be
// popped. The back end stalls while the result queue is full. The
// accumulator's registered update is the one loop that fixes this rate.
// Write the alphabet mode only while no transaction is outstanding; each
// character is classified with the mode in force when it is pushed. When
// status reports an invalid character, bytes already delivered for that
// string should be dropped by the consumer.
module radix_text_to_byte_decoder
    import rtbd_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // character side
    input  logic       push,
    input  t_in_item   i_in,
    output logic       full,
    // result side
    input  logic       pop,
    output t_out_item  o_out,
    output logic       empty,
    // mode register write
    input  logic       i_cfg_valid,
    input  logic [2:0] i_cfg_data,
    output logic       o_cfg_ready
);
    logic [2:0] r_mode;

    t_sym       front_sym, mid_sym;
    logic       mid_empty;
    logic       res_full;
    logic       take;
    t_out_item  result;

    // Mode register, always writable.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_B64;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    rtbd_front u_front (
        .i_mode (r_mode),
        .i_item (i_in),
        .o_sym  (front_sym)
    );

    // Classified characters wait here for the accumulator.
    rtbd_fifo #(
        .DEPTH  (QUEUE_DEPTH_P),
        .t_data (t_sym)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_sym),
        .o_full  (full),
        .i_pop   (take),
        .o_data  (mid_sym),
        .o_empty (mid_empty)
    );

    // Back end advances whenever a symbol waits and the result queue has room.
    assign take = !mid_empty && !res_full;

    rtbd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_sym    (mid_sym),
        .o_result (result)
    );

    rtbd_fifo #(
        .DEPTH  (QUEUE_DEPTH_P),
        .t_data (t_out_item)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_data  (result),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (o_out),
        .o_empty (empty)
    );

endmodule

### hdl/rtbd_checker.sv
// Port-level checks on the decoder's result side, bound to the top level.
`include "assert_macros.svh"

module rtbd_checker
    import rtbd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      pop,
    input logic      empty,
    input t_out_item o_out
);

    `ASSERT_IMPL(a_badlen_at_end, i_clk, i_rst_n, !empty && o_out.status == STATUS_BAD_LEN, o_out.end_of_string, "bad length off string end")
    `ASSERT_IMPL(a_no_byte_on_err, i_clk, i_rst_n, !empty && o_out.byte_valid, o_out.status != STATUS_INVALID, "byte after invalid char")
    `ASSERT_IMPL(a_zero_unused, i_clk, i_rst_n, !empty && !o_out.byte_valid, o_out.data_byte == 8'd0, "data byte not zero")
    `ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_out), "stalled result changed")

endmodule

bind radix_text_to_byte_decoder rtbd_checker u_rtbd_checker (.*);
